// File: hw/rtl/cls_pkg.sv
// ----------------------------------------------------------------------------
// cls_pkg: shared types and constants of the cursor linked sequence
// Index and address widths, operation and status codes, sequencer states
// and the request structs for the link and data stores.
// ----------------------------------------------------------------------------
package cls_pkg;

   // Store geometry. The null index is one past the last entry.
   localparam int CAPACITY   = 256;
   localparam int VALUE_BITS = 32;
   localparam int ADDR_BITS  = $clog2(CAPACITY);
   localparam int IDX_BITS   = ADDR_BITS + 1;
   localparam int MODE_BITS  = 3;
   localparam int STAT_BITS  = 2;

   // Stream beat widths, each rounded up to whole bytes.
   localparam int REQ_FIELD_BITS = MODE_BITS + VALUE_BITS;
   localparam int REQ_TDATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = VALUE_BITS + 1 + IDX_BITS + STAT_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_TDATA_BITS - RSP_FIELD_BITS;

   typedef logic [IDX_BITS-1:0]   idx_type;
   typedef logic [ADDR_BITS-1:0]  addr_type;
   typedef logic [VALUE_BITS-1:0] word_type;
   typedef logic [MODE_BITS-1:0]  mode_type;
   typedef logic [STAT_BITS-1:0]  stat_type;

   localparam idx_type NIL        = idx_type'(CAPACITY);
   localparam idx_type COUNT_FULL = idx_type'(CAPACITY);

   // Operation codes carried in the mode field.
   localparam mode_type MODE_START   = mode_type'(0);
   localparam mode_type MODE_END     = mode_type'(1);
   localparam mode_type MODE_ADVANCE = mode_type'(2);
   localparam mode_type MODE_INSERT  = mode_type'(3);
   localparam mode_type MODE_ATTACH  = mode_type'(4);
   localparam mode_type MODE_REMOVE  = mode_type'(5);
   localparam mode_type MODE_READ    = mode_type'(6);

   // Status codes.
   localparam stat_type ST_OK     = stat_type'(0);
   localparam stat_type ST_FULL   = stat_type'(1);
   localparam stat_type ST_NO_CUR = stat_type'(2);

   typedef enum logic [3:0] {
      S_IDLE,
      S_EXEC,
      S_WALK,
      S_WALK_WAIT,
      S_ADV,
      S_ALLOC,
      S_ALLOC_NEXT,
      S_LINK_PREV,
      S_REM,
      S_REM_FREE,
      S_DATA_RD,
      S_RESP
   } state_type;

   // One read port and one write port on the link store.
   typedef struct packed {
      logic     rd_en;
      addr_type rd_addr;
      logic     wr_en;
      addr_type wr_addr;
      idx_type  wr_data;
   } link_req_type;

   // One read port and one write port on the data store.
   typedef struct packed {
      logic     rd_en;
      addr_type rd_addr;
      logic     wr_en;
      addr_type wr_addr;
      word_type wr_data;
   } data_req_type;

   function automatic logic idx_valid(idx_type i);
      return i < NIL;
   endfunction

   function automatic addr_type idx_addr(idx_type i);
      return i[ADDR_BITS-1:0];
   endfunction

endpackage

// File: hw/rtl/cls_link_store.sv
// ----------------------------------------------------------------------------
// cls_link_store: next-link memory with free-list reset image
// Entries at or above the fill mark have never been written and read back
// as the free-list chain (each points to the next index), so no clearing
// pass is needed after reset.
// ----------------------------------------------------------------------------
module cls_link_store (
   input  logic                 clock,
   input  logic                 reset,
   input  cls_pkg::link_req_type req,
   output cls_pkg::idx_type     rd_data
);
   import cls_pkg::*;

   idx_type  link_mem_ff [CAPACITY];
   idx_type  rd_word_ff;
   addr_type rd_addr_ff;
   logic     rd_fresh_ff;
   idx_type  fill_ff;
   idx_type  fill_in;

   // The fill mark moves up when the first untouched entry is written.
   always_comb begin
      fill_in = fill_ff;
      if (req.wr_en && ({1'b0, req.wr_addr} == fill_ff)) begin
         fill_in = fill_ff + idx_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff <= '0;
      end else begin
         fill_ff <= fill_in;
      end
   end

   // Memory array with a registered read.
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         link_mem_ff[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_word_ff  <= link_mem_ff[req.rd_addr];
         rd_addr_ff  <= req.rd_addr;
         rd_fresh_ff <= ({1'b0, req.rd_addr} >= fill_ff);
      end
   end

   // An untouched entry still holds its reset link.
   assign rd_data = rd_fresh_ff ? (idx_type'(rd_addr_ff) + idx_type'(1)) : rd_word_ff;

endmodule

// File: hw/rtl/cls_data_store.sv
// ----------------------------------------------------------------------------
// cls_data_store: data word memory
// One write port and one registered read port; contents are undefined
// until written.
// ----------------------------------------------------------------------------
module cls_data_store (
   input  logic                 clock,
   input  cls_pkg::data_req_type req,
   output cls_pkg::word_type    rd_data
);
   import cls_pkg::*;

   word_type data_mem_ff [CAPACITY];
   word_type rd_data_ff;

   // Memory array with a registered read.
   always_ff @(posedge clock) begin
      if (req.wr_en) begin
         data_mem_ff[req.wr_addr] <= req.wr_data;
      end
      if (req.rd_en) begin
         rd_data_ff <= data_mem_ff[req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: hw/rtl/cls_ctrl.sv
// ----------------------------------------------------------------------------
// cls_ctrl: operation sequencer for the cursor linked sequence
// Holds head, tail, cursor, previous, free head and count, and steps each
// operation through the shared link-store port one access per cycle.
// ----------------------------------------------------------------------------
module cls_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cls_pkg::mode_type     req_mode,
   input  cls_pkg::word_type     req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output cls_pkg::word_type     rsp_current_value,
   output logic                  rsp_has_current,
   output cls_pkg::idx_type      rsp_item_count,
   output cls_pkg::stat_type     rsp_status,
   output cls_pkg::link_req_type link_req,
   input  cls_pkg::idx_type      link_rd_data,
   output cls_pkg::data_req_type data_req,
   input  cls_pkg::word_type     data_rd_data
);
   import cls_pkg::*;

   state_type state_ff, state_in;
   mode_type  mode_ff, mode_in;
   word_type  value_ff, value_in;
   stat_type  status_ff, status_in;
   idx_type   head_ff, head_in;
   idx_type   tail_ff, tail_in;
   idx_type   cursor_ff, cursor_in;
   idx_type   before_ff, before_in;
   idx_type   count_ff, count_in;
   idx_type   free_head_ff, free_head_in;
   idx_type   walk_ff, walk_in;
   idx_type   node_ff, node_in;
   idx_type   prev_ff, prev_in;
   logic      front_ff, front_in;

   logic      rsp_valid_ff, rsp_valid_in;
   word_type  rsp_value_ff, rsp_value_in;
   logic      rsp_has_ff, rsp_has_in;
   idx_type   rsp_count_ff, rsp_count_in;
   stat_type  rsp_status_ff, rsp_status_in;

   logic cur_valid;
   logic is_full;
   logic walk_more;
   logic rem_at_head;
   logic rsp_load;

   assign cur_valid   = idx_valid(cursor_ff);
   assign is_full     = (count_ff == COUNT_FULL);
   assign walk_more   = idx_valid(walk_ff) && (walk_ff != tail_ff);
   assign rem_at_head = (cursor_ff == head_ff) || !idx_valid(before_ff);
   assign rsp_load    = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ready);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (mode_ff)
               MODE_END: begin
                  state_in = S_WALK;
               end
               MODE_ADVANCE: begin
                  state_in = (cur_valid && (cursor_ff != tail_ff)) ? S_ADV : S_DATA_RD;
               end
               MODE_INSERT, MODE_ATTACH: begin
                  state_in = is_full ? S_DATA_RD : S_ALLOC;
               end
               MODE_REMOVE: begin
                  state_in = cur_valid ? S_REM : S_DATA_RD;
               end
               default: begin
                  state_in = S_DATA_RD;
               end
            endcase
         end
         S_WALK: begin
            state_in = walk_more ? S_WALK_WAIT : S_DATA_RD;
         end
         S_WALK_WAIT: begin
            state_in = S_WALK;
         end
         S_ADV: begin
            state_in = S_DATA_RD;
         end
         S_ALLOC: begin
            state_in = front_ff ? S_DATA_RD : S_ALLOC_NEXT;
         end
         S_ALLOC_NEXT: begin
            state_in = S_LINK_PREV;
         end
         S_LINK_PREV: begin
            state_in = S_DATA_RD;
         end
         S_REM: begin
            state_in = S_REM_FREE;
         end
         S_REM_FREE: begin
            state_in = S_DATA_RD;
         end
         S_DATA_RD: begin
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Store accesses issued in each state.
   always_comb begin
      link_req = '0;
      data_req = '0;
      case (state_ff)
         S_EXEC: begin
            case (mode_ff)
               MODE_ADVANCE: begin
                  link_req.rd_en   = cur_valid && (cursor_ff != tail_ff);
                  link_req.rd_addr = idx_addr(cursor_ff);
               end
               MODE_INSERT, MODE_ATTACH: begin
                  link_req.rd_en    = !is_full;
                  link_req.rd_addr  = idx_addr(free_head_ff);
                  data_req.wr_en    = !is_full;
                  data_req.wr_addr  = idx_addr(free_head_ff);
                  data_req.wr_data  = value_ff;
               end
               MODE_REMOVE: begin
                  link_req.rd_en   = cur_valid;
                  link_req.rd_addr = idx_addr(cursor_ff);
               end
               default: begin
               end
            endcase
         end
         S_WALK: begin
            link_req.rd_en   = walk_more;
            link_req.rd_addr = idx_addr(walk_ff);
         end
         S_ALLOC: begin
            // Front: new node points at the old head. Otherwise fetch the
            // link of the node it follows.
            link_req.wr_en   = front_ff;
            link_req.wr_addr = idx_addr(node_ff);
            link_req.wr_data = head_ff;
            link_req.rd_en   = !front_ff;
            link_req.rd_addr = idx_addr(prev_ff);
         end
         S_ALLOC_NEXT: begin
            link_req.wr_en   = 1'b1;
            link_req.wr_addr = idx_addr(node_ff);
            link_req.wr_data = link_rd_data;
         end
         S_LINK_PREV: begin
            link_req.wr_en   = 1'b1;
            link_req.wr_addr = idx_addr(prev_ff);
            link_req.wr_data = node_ff;
         end
         S_REM: begin
            // Unhook the removed node from its predecessor.
            link_req.wr_en   = !rem_at_head;
            link_req.wr_addr = idx_addr(before_ff);
            link_req.wr_data = link_rd_data;
         end
         S_REM_FREE: begin
            link_req.wr_en   = 1'b1;
            link_req.wr_addr = idx_addr(node_ff);
            link_req.wr_data = free_head_ff;
         end
         S_DATA_RD: begin
            data_req.rd_en   = cur_valid;
            data_req.rd_addr = idx_addr(cursor_ff);
         end
         default: begin
         end
      endcase
   end

   // Pointer and count updates.
   always_comb begin
      mode_in      = mode_ff;
      value_in     = value_ff;
      status_in    = status_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      cursor_in    = cursor_ff;
      before_in    = before_ff;
      count_in     = count_ff;
      free_head_in = free_head_ff;
      walk_in      = walk_ff;
      node_in      = node_ff;
      prev_in      = prev_ff;
      front_in     = front_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               mode_in   = req_mode;
               value_in  = req_value;
               status_in = ST_OK;
            end
         end
         S_EXEC: begin
            case (mode_ff)
               MODE_START: begin
                  cursor_in = head_ff;
                  before_in = NIL;
               end
               MODE_END: begin
                  walk_in = head_ff;
                  node_in = NIL;
               end
               MODE_ADVANCE: begin
                  if (cur_valid) begin
                     before_in = cursor_ff;
                     if (cursor_ff == tail_ff) begin
                        cursor_in = NIL;
                     end
                  end
               end
               MODE_INSERT: begin
                  if (is_full) begin
                     status_in = ST_FULL;
                  end else begin
                     node_in  = free_head_ff;
                     front_in = !cur_valid || !idx_valid(before_ff);
                     prev_in  = before_ff;
                     if (!cur_valid || !idx_valid(before_ff)) begin
                        before_in = NIL;
                     end
                  end
               end
               MODE_ATTACH: begin
                  if (is_full) begin
                     status_in = ST_FULL;
                  end else begin
                     node_in = free_head_ff;
                     if (!cur_valid) begin
                        front_in  = !idx_valid(tail_ff);
                        prev_in   = tail_ff;
                        before_in = tail_ff;
                     end else begin
                        front_in  = 1'b0;
                        prev_in   = cursor_ff;
                        before_in = cursor_ff;
                     end
                  end
               end
               MODE_REMOVE: begin
                  if (!cur_valid) begin
                     status_in = ST_NO_CUR;
                  end else begin
                     node_in = cursor_ff;
                  end
               end
               MODE_READ: begin
                  if (!cur_valid) begin
                     status_in = ST_NO_CUR;
                  end
               end
               default: begin
               end
            endcase
         end
         S_WALK: begin
            if (walk_more) begin
               node_in = walk_ff;
            end else begin
               cursor_in = tail_ff;
               before_in = idx_valid(tail_ff) ? node_ff : NIL;
            end
         end
         S_WALK_WAIT: begin
            walk_in = link_rd_data;
         end
         S_ADV: begin
            cursor_in = link_rd_data;
         end
         S_ALLOC: begin
            free_head_in = link_rd_data;
            count_in     = count_ff + idx_type'(1);
            if (front_ff) begin
               head_in   = node_ff;
               cursor_in = node_ff;
               if (!idx_valid(tail_ff)) begin
                  tail_in = node_ff;
               end
            end
         end
         S_LINK_PREV: begin
            cursor_in = node_ff;
            if (prev_ff == tail_ff) begin
               tail_in = node_ff;
            end
         end
         S_REM: begin
            if (rem_at_head) begin
               head_in   = link_rd_data;
               cursor_in = link_rd_data;
               before_in = NIL;
               if (!idx_valid(link_rd_data)) begin
                  tail_in = NIL;
               end
            end else if (cursor_ff == tail_ff) begin
               tail_in   = before_ff;
               cursor_in = NIL;
            end else begin
               cursor_in = link_rd_data;
            end
         end
         S_REM_FREE: begin
            free_head_in = node_ff;
            count_in     = count_ff - idx_type'(1);
         end
         default: begin
         end
      endcase
   end

   // Result register: a new beat loads once the previous one has left.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_has_in    = rsp_has_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_status_in = rsp_status_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = cur_valid ? data_rd_data : '0;
         rsp_has_in    = cur_valid;
         rsp_count_in  = count_ff;
         rsp_status_in = status_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= NIL;
         tail_ff      <= NIL;
         cursor_ff    <= NIL;
         before_ff    <= NIL;
         count_ff     <= '0;
         free_head_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         cursor_ff    <= cursor_in;
         before_ff    <= before_in;
         count_ff     <= count_in;
         free_head_ff <= free_head_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff       <= mode_in;
      value_ff      <= value_in;
      status_ff     <= status_in;
      walk_ff       <= walk_in;
      node_ff       <= node_in;
      prev_ff       <= prev_in;
      front_ff      <= front_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_has_ff    <= rsp_has_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign req_ready         = (state_ff == S_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_current_value = rsp_value_ff;
   assign rsp_has_current   = rsp_has_ff;
   assign rsp_item_count    = rsp_count_ff;
   assign rsp_status        = rsp_status_ff;

`ifndef SYNTHESIS
   // The count never exceeds the store size.
   assert property (@(posedge clock) disable iff (reset) count_ff <= COUNT_FULL)
      else $error("item count above capacity");

   // An empty sequence has neither head nor tail.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && count_ff == '0) |-> (head_ff == NIL && tail_ff == NIL))
      else $error("empty sequence with a head or tail");

   // The free list is empty exactly when the store is full.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (idx_valid(free_head_ff) == (count_ff != COUNT_FULL)))
      else $error("free list out of step with count");

   // A full status is only reported on a full store.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_load && status_ff == ST_FULL) |-> is_full)
      else $error("full status on a store with room");
`endif

endmodule

// File: hw/rtl/cursor_linked_sequence.sv
// ----------------------------------------------------------------------------
// cursor_linked_sequence: linked sequence of data words with a cursor
// Ordered sequence in a bounded linked store with current and previous
// positions; start, end, advance, insert, attach, remove and read.
//
//   Channel  Direction  Beat contents (lowest bit first)
//   req_     in         mode[2:0], value[34:3], zero pad to 40 bits
//   rsp_     out        current_value[31:0], has_current[32],
//                       item_count[41:33], status[43:42], zero pad to 48 bits
//
// Operations are taken one at a time: req_tready is high only while idle,
// which the sequencer reaches once the previous result beat has loaded. End
// walks the list from the head through the one link-store read port. The result
// register lets the next request in while a result beat is still stalled.
// Reset is synchronous; the link store needs no clearing pass after it.
// ----------------------------------------------------------------------------
module cursor_linked_sequence (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // mode[2:0], value[34:3], zero pad
   input  logic [cls_pkg::REQ_TDATA_BITS-1:0]   req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // current_value[31:0], has_current[32], item_count[41:33], status[43:42]
   output logic [cls_pkg::RSP_TDATA_BITS-1:0]   rsp_tdata
);
   import cls_pkg::*;

   mode_type     req_mode;
   word_type     req_value;
   word_type     rsp_current_value;
   logic         rsp_has_current;
   idx_type      rsp_item_count;
   stat_type     rsp_status;
   link_req_type link_req;
   idx_type      link_rd_data;
   data_req_type data_req;
   word_type     data_rd_data;

   // Unpack the request beat.
   assign req_mode  = req_tdata[MODE_BITS-1:0];
   assign req_value = req_tdata[MODE_BITS +: VALUE_BITS];

   cls_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_tvalid),
      .req_ready         (req_tready),
      .req_mode          (req_mode),
      .req_value         (req_value),
      .rsp_valid         (rsp_tvalid),
      .rsp_ready         (rsp_tready),
      .rsp_current_value (rsp_current_value),
      .rsp_has_current   (rsp_has_current),
      .rsp_item_count    (rsp_item_count),
      .rsp_status        (rsp_status),
      .link_req          (link_req),
      .link_rd_data      (link_rd_data),
      .data_req          (data_req),
      .data_rd_data      (data_rd_data)
   );

   cls_link_store u_link_store (
      .clock   (clock),
      .reset   (reset),
      .req     (link_req),
      .rd_data (link_rd_data)
   );

   cls_data_store u_data_store (
      .clock   (clock),
      .req     (data_req),
      .rd_data (data_rd_data)
   );

   // Pack the result beat.
   assign rsp_tdata = {{RSP_PAD_BITS{1'b0}}, rsp_status, rsp_item_count,
                       rsp_has_current, rsp_current_value};

endmodule

// File: tb/sv/tb_cursor_linked_sequence.sv
// ----------------------------------------------------------------------------
// tb_cursor_linked_sequence: self-checking bench for the cursor linked sequence
// Operation beats go in on the request stream. A behavioral copy of the linked
// store predicts every result beat, and each result is compared field by field.
// Directed corner cases run first. Then come a fill-to-full-and-drain pass,
// weighted random traffic under several idle and stall patterns, and a
// back-pressure run in which the block fills up.
// ----------------------------------------------------------------------------
module tb_cursor_linked_sequence;
   import cls_pkg::*;

   localparam mode_type MODE_UNUSED = mode_type'(7);
   localparam int       MAX_REPORTS = 10;
   localparam int       OP_KINDS    = 8;

   // Operations in the order used by the weight tables below.
   localparam mode_type OP_ORDER [OP_KINDS] = '{MODE_START, MODE_END, MODE_ADVANCE,
      MODE_INSERT, MODE_ATTACH, MODE_REMOVE, MODE_READ, MODE_UNUSED};

   typedef enum {MIX_BALANCED, MIX_GROW, MIX_SHRINK} mix_kind_type;

   // One result beat; the first member lands in the highest bits.
   typedef struct packed {
      stat_type status;
      idx_type  held;
      logic     has_cur;
      word_type cur_value;
   } seq_result_type;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [REQ_TDATA_BITS-1:0] req_tdata  = '0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;

   // Behavioral copy of the linked store.
   word_type word_store [cls_pkg::CAPACITY];
   idx_type  next_link  [cls_pkg::CAPACITY];
   idx_type  seq_head;
   idx_type  seq_tail;
   idx_type  seq_cursor;
   idx_type  seq_prior;
   idx_type  free_top;
   int       seq_len;

   seq_result_type pending_results [$];
   seq_result_type last_prediction;
   int             mismatch_count = 0;
   int             send_idle_pct  = 0;
   int             recv_stall_pct = 0;
   int             hold_left      = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   cursor_linked_sequence dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // Empty sequence with every entry chained on the free list.
   function automatic void clear_sequence();
      for (int i = 0; i < cls_pkg::CAPACITY; i++) begin
         word_store[i] = '0;
         next_link[i]  = idx_type'(i + 1);
      end
      seq_head   = NIL;
      seq_tail   = NIL;
      seq_cursor = NIL;
      seq_prior  = NIL;
      free_top   = '0;
      seq_len    = 0;
   endfunction

   function automatic idx_type link_of(idx_type i);
      return (i < NIL) ? next_link[i[ADDR_BITS-1:0]] : NIL;
   endfunction

   function automatic void put_front(idx_type n);
      next_link[n[ADDR_BITS-1:0]] = seq_head;
      seq_head = n;
      if (seq_tail >= NIL) begin
         seq_tail = n;
      end
   endfunction

   function automatic void put_after(idx_type p, idx_type n);
      next_link[n[ADDR_BITS-1:0]] = link_of(p);
      if (p < NIL) begin
         next_link[p[ADDR_BITS-1:0]] = n;
      end
      if (p == seq_tail) begin
         seq_tail = n;
      end
   endfunction

   // Applies one operation to the copy and returns the result beat it causes.
   function automatic seq_result_type apply_operation(mode_type op, word_type word);
      seq_result_type r;
      logic           had_cur;
      idx_type        walk;
      idx_type        trail;
      idx_type        node;
      int             steps;
      had_cur  = seq_cursor < NIL;
      r.status = ST_OK;
      node     = NIL;

      // Insert and attach both take a free entry first.
      if (op == MODE_INSERT || op == MODE_ATTACH) begin
         if (free_top < NIL && seq_len < cls_pkg::CAPACITY) begin
            node     = free_top;
            free_top = next_link[node[ADDR_BITS-1:0]];
            word_store[node[ADDR_BITS-1:0]] = word;
            next_link[node[ADDR_BITS-1:0]]  = NIL;
            seq_len++;
         end else begin
            r.status = ST_FULL;
         end
      end

      case (op)
         MODE_START: begin
            seq_cursor = seq_head;
            seq_prior  = NIL;
         end
         MODE_END: begin
            // Find the node in front of the tail.
            walk  = seq_head;
            trail = NIL;
            steps = 0;
            while (steps < cls_pkg::CAPACITY && walk < NIL && walk != seq_tail) begin
               trail = walk;
               walk  = link_of(walk);
               steps++;
            end
            seq_cursor = seq_tail;
            seq_prior  = (seq_tail < NIL) ? trail : NIL;
         end
         MODE_ADVANCE: begin
            if (had_cur) begin
               seq_prior  = seq_cursor;
               seq_cursor = (seq_cursor == seq_tail) ? NIL : link_of(seq_cursor);
            end
         end
         MODE_INSERT: begin
            if (node < NIL) begin
               if (!had_cur || seq_prior >= NIL) begin
                  put_front(node);
                  seq_prior = NIL;
               end else begin
                  put_after(seq_prior, node);
               end
               seq_cursor = node;
            end
         end
         MODE_ATTACH: begin
            if (node < NIL) begin
               if (had_cur) begin
                  seq_prior = seq_cursor;
                  put_after(seq_cursor, node);
               end else if (seq_tail < NIL) begin
                  seq_prior = seq_tail;
                  put_after(seq_tail, node);
               end else begin
                  put_front(node);
                  seq_prior = NIL;
               end
               seq_cursor = node;
            end
         end
         MODE_REMOVE: begin
            if (!had_cur) begin
               r.status = ST_NO_CUR;
            end else begin
               node = seq_cursor;
               if (node == seq_head || seq_prior >= NIL) begin
                  seq_head = link_of(node);
                  if (seq_head >= NIL) begin
                     seq_tail = NIL;
                  end
                  seq_cursor = seq_head;
                  seq_prior  = NIL;
               end else begin
                  next_link[seq_prior[ADDR_BITS-1:0]] = link_of(node);
                  if (node == seq_tail) begin
                     seq_tail   = seq_prior;
                     seq_cursor = NIL;
                  end else begin
                     seq_cursor = link_of(node);
                  end
               end
               // The freed entry goes back on top of the free list.
               next_link[node[ADDR_BITS-1:0]] = free_top;
               free_top = node;
               seq_len--;
            end
         end
         MODE_READ: begin
            if (!had_cur) begin
               r.status = ST_NO_CUR;
            end
         end
         default: begin
         end
      endcase

      r.has_cur   = seq_cursor < NIL;
      r.cur_value = r.has_cur ? word_store[seq_cursor[ADDR_BITS-1:0]] : '0;
      r.held      = idx_type'(seq_len);
      return r;
   endfunction

   // Mostly random words, with the all-zero and all-one words now and then.
   function automatic word_type rand_word();
      case ($urandom_range(9))
         0:       return '0;
         1:       return '1;
         default: return word_type'($urandom);
      endcase
   endfunction

   // Weighted choice of operation; the weights of each mix add up to 100.
   function automatic mode_type pick_op(mix_kind_type kind);
      int weights [OP_KINDS];
      int roll;
      case (kind)
         MIX_GROW:   weights = '{4, 1, 10, 38, 38, 4, 4, 1};
         MIX_SHRINK: weights = '{12, 1, 10, 3, 3, 62, 8, 1};
         default:    weights = '{8, 4, 24, 12, 12, 24, 12, 4};
      endcase
      roll = $urandom_range(99);
      for (int m = 0; m < OP_KINDS; m++) begin
         if (roll < weights[m]) begin
            return OP_ORDER[m];
         end
         roll -= weights[m];
      end
      return MODE_READ;
   endfunction

   // Offers one request beat, with a random idle gap in front, and records
   // the predicted result once the beat is taken.
   task automatic send_op(input mode_type op, input word_type word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_TDATA_BITS'({word, op});
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      last_prediction = apply_operation(op, word);
      pending_results.push_back(last_prediction);
   endtask

   // Stops offering beats until every predicted result has come back.
   task automatic wait_all_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic run_random(input int count, input mix_kind_type kind);
      for (int i = 0; i < count; i++) begin
         send_op(pick_op(kind), rand_word());
      end
   endtask

   // Walks every operation through the corner cases of a short list.
   task automatic test_corner_cases();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      // Empty sequence: read, remove, advance, end, start and an unused code with no current item.
      send_op(MODE_READ, '0);
      send_op(MODE_REMOVE, '1);
      send_op(MODE_ADVANCE, '0);
      send_op(MODE_END, '0);
      send_op(MODE_START, '1);
      send_op(MODE_UNUSED, '1);
      // Attach into the empty list, then insert in front of the only item.
      send_op(MODE_ATTACH, '0);
      send_op(MODE_INSERT, '1);
      send_op(MODE_ATTACH, 32'h1234_5678);
      send_op(MODE_ADVANCE, '0);
      // Advance off the tail leaves no current item.
      send_op(MODE_ADVANCE, '0);
      send_op(MODE_READ, '0);
      // Insert with no current item goes to the front.
      send_op(MODE_INSERT, 32'h8000_0001);
      send_op(MODE_ADVANCE, '0);
      // Remove in the middle, then remove the tail.
      send_op(MODE_REMOVE, '0);
      send_op(MODE_ADVANCE, '0);
      send_op(MODE_REMOVE, '0);
      // Attach with no current item goes to the back.
      send_op(MODE_ATTACH, 32'h7FFF_FFFE);
      send_op(MODE_START, '0);
      // Remove at the head leaves no previous item.
      send_op(MODE_REMOVE, '0);
      send_op(MODE_END, '0);
      send_op(MODE_INSERT, word_type'($urandom));
      send_op(MODE_READ, '0);
      send_op(MODE_START, '0);
      send_op(MODE_UNUSED, '0);
   endtask

   // Grows the list until the store reports full several times, then drains it.
   task automatic test_store_full();
      int full_hits;
      int sent;
      send_idle_pct  = 33;
      recv_stall_pct = 33;
      full_hits      = 0;
      sent           = 0;
      while (full_hits < 6 && sent < 700) begin
         send_op(pick_op(MIX_GROW), rand_word());
         if (last_prediction.status == ST_FULL) begin
            full_hits++;
         end
         sent++;
      end
      sent = 0;
      while (seq_len != 0 && sent < 800) begin
         send_op(pick_op(MIX_SHRINK), rand_word());
         sent++;
      end
      run_random(20, MIX_SHRINK);
   endtask

   // Balanced traffic under each idle and stall pattern in turn.
   task automatic test_idle_patterns();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      run_random(160, MIX_BALANCED);
      send_idle_pct  = 52;
      recv_stall_pct = 0;
      run_random(160, MIX_BALANCED);
      send_idle_pct  = 0;
      recv_stall_pct = 52;
      run_random(160, MIX_BALANCED);
      send_idle_pct  = 33;
      recv_stall_pct = 33;
      run_random(160, MIX_BALANCED);
   endtask

   // Long receiver hold-off while beats keep coming, then a full sender pause.
   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_left      = 300;
      run_random(40, MIX_BALANCED);
      wait_all_results();
      run_random(20, MIX_BALANCED);
   endtask

   // Result channel ready, with random stalls and the long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_tready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Compares each result beat with the oldest prediction.
   always @(posedge clock) begin
      seq_result_type want;
      seq_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = seq_result_type'(rsp_tdata[RSP_FIELD_BITS-1:0]);
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
               $display("%0t: unexpected result beat %h", $realtime, rsp_tdata);
            end
         end else begin
            want = pending_results.pop_front();
            if (got.cur_value !== want.cur_value || got.has_cur !== want.has_cur ||
                got.held !== want.held || got.status !== want.status) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $display("%0t: mismatch expected value %h cur %b count %0d status %0d",
                           $realtime, want.cur_value, want.has_cur, want.held, want.status);
                  $display("%0t:          actual   value %h cur %b count %0d status %0d",
                           $realtime, got.cur_value, got.has_cur, got.held, got.status);
               end
            end
         end
      end
   end

   initial begin
      clear_sequence();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_corner_cases();
      test_store_full();
      test_idle_patterns();
      test_backpressure();
      wait_all_results();
      repeat (600) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_cursor_linked_sequence: PASS");
      end else begin
         $display("tb_cursor_linked_sequence: FAIL");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #60_000_000;
      $display("tb_cursor_linked_sequence: FAIL");
      $finish;
   end

endmodule

// File: files.f
hw/rtl/cls_pkg.sv
hw/rtl/cls_link_store.sv
hw/rtl/cls_data_store.sv
hw/rtl/cls_ctrl.sv
hw/rtl/cursor_linked_sequence.sv
tb/sv/tb_cursor_linked_sequence.sv
